// ===== rtl/core/ffa_pkg.sv =====
// Package for the first-fit free-list allocator: modes, status codes, widths.
// No dependencies.
`default_nettype none
package ffa_pkg;
   localparam int HeapGranules = 4096;
   localparam int FreeDepth    = 64;
   localparam int GranuleBytes = 16;
   localparam int SizeW        = 13;

   typedef enum logic [1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_FREE   = 2'd1,
      MODE_ZALLOC = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_ZERO     = 3'd1,
      ST_NOHEAP   = 3'd2,
      ST_FULL     = 3'd3,
      ST_NULLFREE = 3'd4
   } status_type;
endpackage
`default_nettype wire

// ===== rtl/core/ffa_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ffa_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/first_fit_free_list_allocator.sv =====
// Top level of the first-fit free-list allocator.
// Depends on ffa_pkg and ffa_ram (free list store and block size store).
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | mode, request_size, count, address
//  rsp     | out       | rsp_valid/rsp_stall  | result_address, status, reused
//
// One transaction at a time. Allocate walks the free entries from the newest
// down, reading and comparing each one; on a hit it shifts the later entries
// down one by one to close the hole, else the bump pointer serves it. Release
// does one block size lookup. Zeroed allocate adds a multiply state. Reset
// clears the list count and bump pointer; memories hold no reset. A stalled
// result holds in the output register; a finished transaction waits in its
// last state until it drains.
`default_nettype none
module first_fit_free_list_allocator
   import ffa_pkg::*;
#(
   parameter int HEAP_GRANULES = ffa_pkg::HeapGranules,
   parameter int FREE_DEPTH    = ffa_pkg::FreeDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [15:0] req_request_size,
   input  wire logic [15:0] req_count,
   input  wire logic [15:0] req_address,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_result_address,
   output logic [2:0]       rsp_status,
   output logic             rsp_reused
);
   localparam int HW = $clog2(HEAP_GRANULES);
   localparam int FW = $clog2(FREE_DEPTH);
   localparam int CW = $clog2(FREE_DEPTH + 1);
   localparam int EW = HW + SizeW;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MUL   = 10'b0000000010,
      S_NEED  = 10'b0000000100,
      S_RD    = 10'b0000001000,
      S_CMP   = 10'b0000010000,
      S_SHRD  = 10'b0000100000,
      S_SHWR  = 10'b0001000000,
      S_BUMP  = 10'b0010000000,
      S_FRD   = 10'b0100000000,
      S_FWR   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic [15:0]   size_ff, size_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic [15:0]   addr_ff, addr_in;
   logic [31:0]   bytes_ff, bytes_in;
   logic [28:0]   need_ff, need_in;
   logic [CW-1:0] fcount_ff, fcount_in;
   logic [HW:0]   bump_ff, bump_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [HW-1:0] gran_ff, gran_in;
   logic          busy_ff, busy_in;
   logic          ovalid_ff, ovalid_in;
   logic [15:0]   oaddr_ff, oaddr_in;
   logic [2:0]    ostat_ff, ostat_in;
   logic          oreuse_ff, oreuse_in;

   // free list memory
   logic          fl_we;
   logic [FW-1:0] fl_wa, fl_ra;
   logic [EW-1:0] fl_wd, fl_rd;
   // block size memory
   logic          bs_we;
   logic [HW-1:0] bs_wa, bs_ra;
   logic [SizeW-1:0] bs_wd, bs_rd;

   ffa_ram #(.Width(EW), .Depth(FREE_DEPTH)) u_free (
      .clock, .wr_en(fl_we), .wr_addr(fl_wa), .wr_data(fl_wd),
      .rd_addr(fl_ra), .rd_data(fl_rd));
   ffa_ram #(.Width(SizeW), .Depth(HEAP_GRANULES)) u_size (
      .clock, .wr_en(bs_we), .wr_addr(bs_wa), .wr_data(bs_wd),
      .rd_addr(bs_ra), .rd_data(bs_rd));

   logic [HW-1:0]    ent_start;
   logic [SizeW-1:0] ent_size;
   logic [15:0]      fr_off;
   logic [29:0]      bump_sum;
   assign ent_start = fl_rd[EW-1:SizeW];
   assign ent_size  = fl_rd[SizeW-1:0];
   assign fr_off    = req_address - 16'd8;
   assign bump_sum  = 30'(bump_ff) + 30'(need_ff);

   assign req_stall = busy_ff;
   assign rsp_valid = ovalid_ff;
   assign rsp_result_address = oaddr_ff;
   assign rsp_status = ostat_ff;
   assign rsp_reused = oreuse_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff; mode_in = mode_ff; size_in = size_ff; cnt_in = cnt_ff;
      addr_in = addr_ff; bytes_in = bytes_ff; need_in = need_ff;
      fcount_in = fcount_ff; bump_in = bump_ff; idx_in = idx_ff; gran_in = gran_ff;
      busy_in = busy_ff; ovalid_in = ovalid_ff; oaddr_in = oaddr_ff;
      ostat_in = ostat_ff; oreuse_in = oreuse_ff;
      fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = '0;
      bs_we = 1'b0; bs_wa = '0; bs_wd = '0; bs_ra = gran_ff;
      if (ovalid_ff && !rsp_stall) begin
         ovalid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (!busy_ff && req_valid) begin
               mode_in = req_mode; size_in = req_request_size; cnt_in = req_count;
               addr_in = req_address;
               gran_in = HW'(fr_off[15:4]);
               bytes_in = {16'd0, req_request_size};
               busy_in = 1'b1;
               case (mode_type'(req_mode))
                  MODE_ALLOC:  state_in = S_NEED;
                  MODE_ZALLOC: state_in = S_MUL;
                  MODE_FREE:   state_in = S_FRD;
                  default:     state_in = S_FWR;
               endcase
            end
         end
         S_MUL: begin
            if (cnt_ff == 16'd0 || size_ff == 16'd0) begin
               oaddr_in = '0; ostat_in = ST_ZERO; oreuse_in = 1'b0;
               ovalid_in = 1'b1; state_in = S_IDLE; busy_in = 1'b0;
            end else begin
               bytes_in = cnt_ff * size_ff;
               state_in = S_NEED;
            end
         end
         S_NEED: begin
            need_in = 29'(({1'b0, bytes_ff} + 33'd23) >> 4);
            idx_in = fcount_ff;
            state_in = S_RD;
         end
         S_RD: begin
            if (idx_ff == '0) begin
               state_in = S_BUMP;
            end else begin
               fl_ra = FW'(idx_ff - 1'b1);
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            // hold the hit start until the result is written
            if (29'(ent_size) >= need_ff) begin
               gran_in = ent_start;
               fcount_in = fcount_ff - 1'b1;
               state_in = S_SHRD;
            end else begin
               idx_in = idx_ff - 1'b1;
               state_in = S_RD;
            end
         end
         S_SHRD: begin
            // idx_ff-1 is the hole; move entry idx_ff down
            if (idx_ff >= CW'(fcount_ff + 1'b1)) begin
               oaddr_in = 16'({gran_ff, 4'd8}); ostat_in = ST_OK; oreuse_in = 1'b1;
               ovalid_in = 1'b1; state_in = S_IDLE; busy_in = 1'b0;
            end else begin
               fl_ra = FW'(idx_ff);
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            fl_we = 1'b1; fl_wa = FW'(idx_ff - 1'b1); fl_wd = fl_rd;
            idx_in = idx_ff + 1'b1;
            state_in = S_SHRD;
         end
         S_BUMP: begin
            oreuse_in = 1'b0;
            if (bump_sum > 30'(HEAP_GRANULES)) begin
               oaddr_in = '0; ostat_in = ST_NOHEAP;
            end else begin
               bs_we = 1'b1; bs_wa = bump_ff[HW-1:0]; bs_wd = need_ff[SizeW-1:0];
               oaddr_in = 16'({bump_ff[HW-1:0], 4'd8}); ostat_in = ST_OK;
               bump_in = bump_sum[HW:0];
            end
            ovalid_in = 1'b1; state_in = S_IDLE; busy_in = 1'b0;
         end
         S_FRD: begin
            // block size read issued via bs_ra = gran_ff
            state_in = S_FWR;
         end
         S_FWR: begin
            oaddr_in = '0; oreuse_in = 1'b0;
            if (mode_ff == MODE_FREE) begin
               if (addr_ff == 16'd0) begin
                  ostat_in = ST_NULLFREE;
               end else if (fcount_ff >= CW'(FREE_DEPTH)) begin
                  ostat_in = ST_FULL;
               end else begin
                  fl_we = 1'b1; fl_wa = FW'(fcount_ff);
                  fl_wd = {gran_ff, bs_rd};
                  fcount_in = fcount_ff + 1'b1;
                  ostat_in = ST_OK;
               end
            end else begin
               ostat_in = ST_OK;
            end
            ovalid_in = 1'b1; state_in = S_IDLE; busy_in = 1'b0;
         end
         default: state_in = S_IDLE;
      endcase
      // wait for output register to drain before the next transaction ends
      if ((state_in == S_IDLE) && busy_ff && !busy_in && ovalid_ff && rsp_stall) begin
         state_in = state_ff; busy_in = 1'b1; ovalid_in = 1'b1;
         oaddr_in = oaddr_ff; ostat_in = ostat_ff; oreuse_in = oreuse_ff;
         fcount_in = fcount_ff; bump_in = bump_ff; fl_we = 1'b0; bs_we = 1'b0;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; busy_ff <= 1'b0; ovalid_ff <= 1'b0;
         fcount_ff <= '0; bump_ff <= '0;
      end else begin
         state_ff <= state_in; busy_ff <= busy_in; ovalid_ff <= ovalid_in;
         fcount_ff <= fcount_in; bump_ff <= bump_in;
      end
      mode_ff <= mode_in; size_ff <= size_in; cnt_ff <= cnt_in; addr_ff <= addr_in;
      bytes_ff <= bytes_in; need_ff <= need_in; idx_ff <= idx_in; gran_ff <= gran_in;
      oaddr_ff <= oaddr_in; ostat_ff <= ostat_in; oreuse_ff <= oreuse_in;
   end

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= CW'(FREE_DEPTH)) else $error("free count overflow");
   a_bump_range: assert property (@(posedge clock) disable iff (reset)
      bump_ff <= (HW+1)'(HEAP_GRANULES)) else $error("bump pointer overflow");
   a_null_noreuse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_address == 16'd0 |-> !rsp_reused)
      else $error("reuse flag on null result");
endmodule
`default_nettype wire
